// ===== sv/bpe_pkg.sv =====
// shared types and constants of the bit error pattern enumerator
`default_nettype none
package bpe_pkg;
    localparam int MaxWeight    = 16;
    localparam int MaxPositions = 1024;
    localparam int BaseWords    = 16;
    localparam int PosW         = 10;
    localparam int CntW         = 11;
    localparam int WgtW         = 5;
    localparam int IdxW         = 4;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_NEXT  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [1:0] REG_WEIGHT = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_UNIQUE = 2'd2;

    // command handed from front to back
    typedef struct packed {
        logic       start;
        logic [4:0] weight;
        logic [10:0] count;
        logic       uniq;
    } cmd_t;
endpackage
`default_nettype wire

// ===== sv/bpe_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module bpe_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== sv/bpe_front.sv =====
// front end: config registers, base vector loads, command queue
`default_nettype none
module bpe_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [10:0]         cfg_data,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [1:0]          s_tuser,
    input  wire logic [71:0]         s_tdata,
    output logic                     q_valid,
    input  wire logic                q_ready,
    output bpe_pkg::cmd_t            q_cmd,
    input  wire logic [5:0]          base_word_sel,
    output logic [63:0]              base_word
);
    import bpe_pkg::*;

    logic [4:0]  weight_reg;
    logic [10:0] count_reg;
    logic        unique_reg;
    logic [63:0] base_reg [BaseWords];
    // two-entry command queue
    cmd_t        qd_reg [2];
    logic        qwr_reg, qrd_reg;
    logic [1:0]  qcnt_reg;
    logic [1:0]  op;
    logic        accept, push, pop;
    cmd_t        cmd;

    assign op       = s_tuser;
    // a load waits until the command queue is empty and the back end is idle
    assign s_tready = (qcnt_reg != 2'd2) &&
                      (op != OP_LOAD || (qcnt_reg == 2'd0 && q_ready));
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (op == OP_START || op == OP_NEXT);
    assign pop      = q_valid && q_ready;
    assign q_valid  = (qcnt_reg != 2'd0);
    assign q_cmd    = qd_reg[qrd_reg];
    assign base_word = base_word_sel[5:4] == 2'd0 ? base_reg[base_word_sel[3:0]] : 64'd0;

    // latch weight and count saturated
    always_comb
    begin
        cmd.start  = (op == OP_START);
        cmd.weight = (weight_reg > 5'(MaxWeight)) ? 5'(MaxWeight) : weight_reg;
        cmd.count  = (count_reg > 11'(MaxPositions)) ? 11'(MaxPositions) : count_reg;
        cmd.uniq   = unique_reg;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= 5'd1;
            count_reg  <= 11'd1024;
            unique_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WEIGHT: weight_reg <= cfg_data[4:0];
                REG_COUNT:  count_reg  <= cfg_data;
                REG_UNIQUE: unique_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // base vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BaseWords; i++)
            begin
                base_reg[i] <= 64'd0;
            end
        end
        else if (accept && op == OP_LOAD)
        begin
            base_reg[s_tdata[3:0]] <= s_tdata[67:4];
        end
    end

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qwr_reg  <= 1'b0;
            qrd_reg  <= 1'b0;
            qcnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                qwr_reg <= ~qwr_reg;
            end
            if (pop)
            begin
                qrd_reg <= ~qrd_reg;
            end
            qcnt_reg <= qcnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qd_reg[qwr_reg] <= cmd;
        end
    end
endmodule
`default_nettype wire

// ===== sv/bpe_back.sv =====
// back end: candidate scan, combination advance and position emission
`default_nettype none
module bpe_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  bpe_pkg::cmd_t    q_cmd,
    output logic [5:0]       base_word_sel,
    input  wire logic [63:0] base_word,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    import bpe_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_ADV   = 7'b0000100,
        ST_FILL  = 7'b0001000,
        ST_RD    = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_ONE   = 7'b1000000
    } state_t;

    state_t      state_reg;
    logic [4:0]  wgt_reg;
    logic [10:0] live_reg;
    logic        done_reg;
    logic [9:0]  ch_reg [MaxWeight];
    logic [10:0] scan_reg, lim_reg;
    logic        uniq_reg;
    logic [4:0]  k_reg;
    logic        rdwait_reg;
    logic        exh_reg;
    // output register
    logic        ov_reg, olast_reg, opv_reg, oexh_reg;
    logic [9:0]  opos_reg;

    logic        ram_we;
    logic [9:0]  ram_addr, ram_wdata, ram_rdata;
    logic        cand_ok, out_free;
    logic [3:0]  km1, ki;

    bpe_ram #(.Width(PosW), .Depth(MaxPositions)) u_cand (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign out_free      = !ov_reg || m_tready;
    assign q_ready       = (state_reg == ST_IDLE);
    assign base_word_sel = scan_reg[10:5] >> 1;
    assign cand_ok       = !uniq_reg || !base_word[scan_reg[5:0]];
    assign ram_we        = (state_reg == ST_SCAN) && (scan_reg != lim_reg) && cand_ok;
    assign ram_wdata     = scan_reg[9:0];
    assign ki            = k_reg[3:0];
    assign km1           = wgt_reg[3:0] - 4'd1;
    assign ram_addr      = ram_we ? live_reg[9:0] : ch_reg[ki];

    assign m_tvalid = ov_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {6'd0, opos_reg};
    assign m_tuser  = {oexh_reg, opv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wgt_reg    <= 5'd0;
            live_reg   <= 11'd0;
            done_reg   <= 1'b1;
            scan_reg   <= 11'd0;
            lim_reg    <= 11'd0;
            uniq_reg   <= 1'b0;
            k_reg      <= 5'd0;
            rdwait_reg <= 1'b0;
            exh_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            olast_reg  <= 1'b0;
            opv_reg    <= 1'b0;
            oexh_reg   <= 1'b0;
            opos_reg   <= 10'd0;
            for (int i = 0; i < MaxWeight; i++)
            begin
                ch_reg[i] <= 10'd0;
            end
        end
        else
        begin
            // output drained; the emitting states reload it themselves
            if (ov_reg && m_tready && state_reg != ST_EMIT && state_reg != ST_ONE)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_cmd.start)
                        begin
                            wgt_reg  <= q_cmd.weight;
                            lim_reg  <= q_cmd.count;
                            uniq_reg <= q_cmd.uniq;
                            scan_reg <= 11'd0;
                            live_reg <= 11'd0;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_ADV;
                        end
                    end
                end
                // build candidate list, one position a cycle
                ST_SCAN:
                begin
                    if (scan_reg == lim_reg)
                    begin
                        k_reg <= 5'd0;
                        if ({6'd0, wgt_reg} > live_reg)
                        begin
                            done_reg <= 1'b1;
                            exh_reg  <= 1'b1;
                            state_reg <= ST_ONE;
                        end
                        else
                        begin
                            done_reg <= 1'b0;
                            exh_reg  <= 1'b0;
                            state_reg <= ST_FILL;
                        end
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 11'd1;
                        if (cand_ok)
                        begin
                            live_reg <= live_reg + 11'd1;
                        end
                    end
                end
                ST_FILL:
                begin
                    if (exh_reg)
                    begin
                        // refill after mobile bump: chain the tail upward
                        if (k_reg < wgt_reg)
                        begin
                            ch_reg[ki] <= ch_reg[4'(k_reg - 5'd1)] + 10'd1;
                            k_reg <= k_reg + 5'd1;
                        end
                        else
                        begin
                            k_reg <= 5'd0;
                            exh_reg <= 1'b0;
                            rdwait_reg <= 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                    else
                    begin
                        // initial indices 0..w-1
                        ch_reg[ki] <= {5'd0, k_reg};
                        if (k_reg == 5'(MaxWeight - 1))
                        begin
                            k_reg <= 5'd0;
                            rdwait_reg <= 1'b1;
                            if (wgt_reg == 5'd0)
                            begin
                                state_reg <= ST_ONE;
                            end
                            else
                            begin
                                state_reg <= ST_RD;
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + 5'd1;
                        end
                    end
                end
                // one advance step: find mobile index scanning down
                ST_ADV:
                begin
                    if (done_reg)
                    begin
                        exh_reg <= 1'b1;
                        state_reg <= ST_ONE;
                    end
                    else if (wgt_reg == 5'd0)
                    begin
                        done_reg <= 1'b1;
                        exh_reg  <= 1'b1;
                        state_reg <= ST_ONE;
                    end
                    else if ({1'b0, ch_reg[km1]} + 11'd1 != live_reg)
                    begin
                        ch_reg[km1] <= ch_reg[km1] + 10'd1;
                        k_reg <= 5'd0;
                        rdwait_reg <= 1'b1;
                        state_reg <= ST_RD;
                    end
                    else
                    begin
                        // walk down from w-2, one index per cycle
                        if (k_reg == 5'd0)
                        begin
                            k_reg <= wgt_reg;
                        end
                        else if (k_reg == 5'd1)
                        begin
                            done_reg <= 1'b1;
                            exh_reg  <= 1'b1;
                            k_reg    <= 5'd0;
                            state_reg <= ST_ONE;
                        end
                        else if (ch_reg[4'(k_reg - 5'd2)] + 10'd1 != ch_reg[4'(k_reg - 5'd1)])
                        begin
                            ch_reg[4'(k_reg - 5'd2)] <= ch_reg[4'(k_reg - 5'd2)] + 10'd1;
                            k_reg <= k_reg - 5'd1;
                            state_reg <= ST_FILL;
                            exh_reg <= 1'b1;
                        end
                        else
                        begin
                            k_reg <= k_reg - 5'd1;
                        end
                    end
                end
                ST_RD:
                begin
                    rdwait_reg <= 1'b0;
                    if (!rdwait_reg)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                // emit one position
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        opos_reg  <= ram_rdata;
                        opv_reg   <= 1'b1;
                        oexh_reg  <= 1'b0;
                        olast_reg <= (k_reg + 5'd1 == wgt_reg);
                        if (k_reg + 5'd1 == wgt_reg)
                        begin
                            state_reg <= ST_IDLE;
                            k_reg <= 5'd0;
                        end
                        else
                        begin
                            k_reg <= k_reg + 5'd1;
                            rdwait_reg <= 1'b1;
                            state_reg <= ST_RD;
                        end
                    end
                    else
                    begin
                        ov_reg <= 1'b1;
                    end
                end
                ST_ONE:
                begin
                    if (out_free)
                    begin
                        ov_reg    <= 1'b1;
                        opos_reg  <= 10'd0;
                        opv_reg   <= 1'b0;
                        olast_reg <= 1'b1;
                        oexh_reg  <= exh_reg;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        ov_reg <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/bit_error_pattern_enumerator_unit.sv =====
// Bit error pattern enumerator: lexicographic weight-of-size combinations.
// Start: dequeue, candidate scan and index setup, then for each emitted position
// a read wait, a read and an emit.
// Next: dequeue, carry search and tail refill, then the same read wait, read and
// emit per position; output stalls lengthen both. Loads wait for an empty queue and
// an idle back end; reset clears the base vector, restores default regs, sets the done flag.
`default_nettype none
module bit_error_pattern_enumerator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,  // op[1:0]
    input  wire logic [71:0] s_tdata,  // word_index[3:0], word_value[67:4]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // bit_position[9:0]
    output logic [1:0]       m_tuser,  // position_valid[0], exhausted[1]
    output logic             m_tlast   // last_of_pattern
);
    import bpe_pkg::*;

    logic        q_valid, q_ready;
    cmd_t        q_cmd;
    logic [5:0]  base_word_sel;
    logic [63:0] base_word;

    bpe_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tuser(s_tuser), .s_tdata(s_tdata), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .base_word_sel(base_word_sel), .base_word(base_word)
    );

    bpe_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .base_word_sel(base_word_sel), .base_word(base_word),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );
endmodule
`default_nettype wire

// ===== sim/tb_bit_error_pattern_enumerator_unit.sv =====
// testbench of the bit error pattern enumerator: predicted patterns checked against the stream
`default_nettype none
module tb_bit_error_pattern_enumerator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import bpe_pkg::*;

    typedef struct packed {
        logic [9:0] position;
        logic       pos_valid;
        logic       last;
        logic       exhausted;
    } pattern_bit_t;

    // predictor of the enumerator plus queue of predicted pattern bits
    class pattern_scoreboard;
        logic [63:0]  base_words [BaseWords];
        logic [9:0]   candidates [MaxPositions];
        int unsigned  live_count;
        int unsigned  chosen [MaxWeight];
        bit           done;
        int unsigned  latched_weight;
        int unsigned  weight_reg;
        int unsigned  count_reg;
        bit           unique_reg;
        pattern_bit_t pending [$];
        int           mismatches;
        int           results_seen;

        function new();
            for (int i = 0; i < BaseWords; i++) base_words[i] = '0;
            for (int i = 0; i < MaxWeight; i++) chosen[i] = 0;
            live_count = 0;
            done = 1;
            latched_weight = 0;
            weight_reg = 1;
            count_reg = 1024;
            unique_reg = 0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] value);
            if (idx == REG_WEIGHT) weight_reg = value[4:0];
            else if (idx == REG_COUNT) count_reg = value;
            else if (idx == REG_UNIQUE) unique_reg = value[0];
        endfunction

        function void push(logic [9:0] pos, bit v, bit l, bit e);
            pattern_bit_t r;
            r.position = pos;
            r.pos_valid = v;
            r.last = l;
            r.exhausted = e;
            pending.push_back(r);
        endfunction

        function void push_pattern();
            if (latched_weight == 0) begin
                push(10'd0, 0, 1, 0);
                return;
            end
            for (int i = 0; i < latched_weight; i++)
                push(candidates[chosen[i] % MaxPositions], 1, i + 1 == latched_weight, 0);
        endfunction

        function bit step_forward();
            int mobile;
            int w;
            mobile = -1;
            w = latched_weight;
            if (done) return 0;
            if (w == 0) begin
                done = 1;
                return 0;
            end
            if (chosen[w-1] + 1 != live_count) begin
                chosen[w-1]++;
                return 1;
            end
            for (int i = w - 2; i >= 0; i--)
                if (chosen[i] + 1 != chosen[i+1]) begin
                    mobile = i;
                    break;
                end
            if (mobile < 0) begin
                done = 1;
                return 0;
            end
            chosen[mobile]++;
            for (int i = mobile + 1; i < w; i++) chosen[i] = chosen[i-1] + 1;
            return 1;
        endfunction

        // note an accepted input transaction
        function void note_input(op_t op, logic [3:0] widx, logic [63:0] wval);
            int unsigned span;
            bit zero_bit;
            case (op)
                OP_LOAD: base_words[widx] = wval;
                OP_START:
                begin
                    span = count_reg > MaxPositions ? MaxPositions : count_reg;
                    latched_weight = weight_reg > MaxWeight ? MaxWeight : weight_reg;
                    live_count = 0;
                    for (int p = 0; p < span; p++) begin
                        zero_bit = (p >> 6) >= BaseWords ? 1 : !base_words[p >> 6][p & 63];
                        if (!unique_reg || zero_bit) begin
                            candidates[live_count] = p[9:0];
                            live_count++;
                        end
                    end
                    for (int i = 0; i < MaxWeight; i++) chosen[i] = i < latched_weight ? i : 0;
                    done = latched_weight > live_count;
                    if (done) push(10'd0, 0, 1, 1);
                    else push_pattern();
                end
                OP_NEXT:
                begin
                    if (!step_forward()) push(10'd0, 0, 1, 1);
                    else push_pattern();
                end
                default: ;
            endcase
        endfunction

        // check an accepted output transaction
        function void check_result(logic [15:0] data, logic [1:0] user, logic tlast);
            pattern_bit_t got;
            pattern_bit_t exp_bit;
            got.position = data[9:0];
            got.pos_valid = user[0];
            got.last = tlast;
            got.exhausted = user[1];
            results_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h user %b (tlast %b)", $time, data, user,
                         tlast);
                mismatches++;
                return;
            end
            exp_bit = pending.pop_front();
            if (got.position !== exp_bit.position)
                $display("%0t: bit_position expected %0d actual %0d", $time,
                         exp_bit.position, got.position);
            if (got.pos_valid !== exp_bit.pos_valid)
                $display("%0t: position_valid expected %b actual %b", $time,
                         exp_bit.pos_valid, got.pos_valid);
            if (got.last !== exp_bit.last)
                $display("%0t: last_of_pattern expected %b actual %b", $time,
                         exp_bit.last, got.last);
            if (got.exhausted !== exp_bit.exhausted)
                $display("%0t: exhausted expected %b actual %b", $time,
                         exp_bit.exhausted, got.exhausted);
            if (data[15:10] !== 6'b0)
                $display("%0t: tdata padding expected 0 actual %h", $time, data[15:10]);
            if (got !== exp_bit || data[15:10] !== 6'b0)
                mismatches++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    pattern_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    int unsigned cycle_count;
    int unsigned inputs_sent;

    bit_error_pattern_enumerator_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("tb_bit_error_pattern_enumerator_unit: errors");
            $finish;
        end
    end

    // receiver: random stall, check each accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser, m_tlast);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays high between items and while waiting for ready; idle cycles drop it
    task automatic send_item(op_t op, logic [3:0] widx, logic [63:0] wval);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {4'b0, wval, widx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_input(op, widx, wval);
        inputs_sent++;
    endtask

    // drain until the queue is empty, then allow for a trailing load
    task automatic settle();
        s_tvalid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        board.write_reg(idx, value);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic set_config(int w, int c, bit u);
        write_reg(REG_WEIGHT, w[10:0]);
        write_reg(REG_COUNT, c[10:0]);
        write_reg(REG_UNIQUE, {10'b0, u});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one enumeration run: start and a burst of next items
    task automatic run_enum(int nexts);
        send_item(OP_START, 4'($urandom), rand64());
        for (int i = 0; i < nexts; i++) send_item(OP_NEXT, 4'($urandom), rand64());
    endtask

    task automatic random_phase(int items);
        int k;
        int w;
        int c;
        int nl;
        while (items > 0) begin
            settle();
            k = $urandom_range(9);
            w = k == 0 ? $urandom_range(31, 17) : $urandom_range(4);
            c = k == 1 ? $urandom_range(2047, 1024) : $urandom_range(12);
            set_config(w, c, $urandom_range(1));
            nl = $urandom_range(3);
            for (int i = 0; i < nl; i++)
                send_item(OP_LOAD, 4'($urandom_range(1)),
                          $urandom_range(1) ? rand64() : ~64'(1 << $urandom_range(12)));
            items -= nl;
            if ($urandom_range(9) == 0)
            begin
                send_item(OP_NONE, 4'($urandom), rand64());
                items -= 1;
            end
            k = $urandom_range(3, 20);
            run_enum(k);
            items -= k + 1;
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycle_count = 0;
        inputs_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: next before start, unused op, reset settings, extremes
        send_item(OP_NEXT, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_NONE, 4'h0, 64'h0);
        send_item(OP_LOAD, 4'h0, 64'hFFFF_FFFF_FFFF_FF5A);
        send_item(OP_LOAD, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
        run_enum(2);
        settle();
        set_config(0, 5, 0);
        run_enum(2);
        settle();
        set_config(16, 16, 0);
        run_enum(3);
        settle();
        set_config(31, 2047, 1);
        run_enum(2);
        settle();
        set_config(3, 8, 1);
        send_item(OP_START, 4'h0, 64'h0);
        settle();
        write_reg(REG_WEIGHT, 11'd1);
        run_enum(3);
        settle();
        set_config(1, 0, 0);
        run_enum(1);
        send_item(OP_LOAD, 4'h0, 64'h0);

        // random phases with varying back-pressure
        random_phase(100);
        send_idle_pct = 56;
        random_phase(100);
        send_idle_pct = 0;
        recv_stall_pct = 56;
        random_phase(100);
        send_idle_pct = 26;
        recv_stall_pct = 26;
        random_phase(100);

        settle();
        repeat (50) @(posedge clk);
        $display("covered %0d input transactions and %0d result transactions", inputs_sent,
                 board.results_seen);
        $display("weights 0..31, counts 0..2047, plain and unique modes, exhausted cases");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb_bit_error_pattern_enumerator_unit: clean");
        else
            $display("tb_bit_error_pattern_enumerator_unit: errors");
        $finish;
    end
endmodule
`default_nettype wire
